// ===== hw/rtl/frt_pkg.sv =====
// shared codes and types for the fragment reassembly tracker
package frt_pkg;

  localparam logic [1:0] ACT_ACCEPT = 2'd0;
  localparam logic [1:0] ACT_PRUNE  = 2'd1;
  localparam logic [1:0] ACT_CHECK  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] STS_REJECTED   = 2'd0;
  localparam logic [1:0] STS_INCOMPLETE = 2'd1;
  localparam logic [1:0] STS_COMPLETED  = 2'd2;
  localparam logic [1:0] STS_NO_SLOT    = 2'd3;

  localparam logic [63:0] BUDGET_RESET = 64'd600;
  localparam logic [3:0]  ADDR_BUDGET  = 4'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_stall;
    logic out_valid;
    logic rd_en;
  } ctrl_t;

endpackage

// ===== hw/rtl/fragment_reassembly_tracker.sv =====
// fragment reassembly tracker: slot table in one memory, swept one slot per cycle
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | action, ids, index, count, now_tick
//  out_    | output    | out_valid/out_stall | status, slot, msg id, drops, consistent
//  cfg     | apb       | psel/penable/pready | budget_ticks at byte address 0
//
// accepted beat to result beat: one memory read per slot, a drain of the last read,
// the close of the sweep and the table update
// a bad fragment or unused action skips the sweep: no slot is read for it
// the next input beat can be taken in the cycle after the result beat leaves
// reset clears all slot valid bits and the drop count at once, no clearing pass
// in_stall is high from acceptance until the result beat leaves
module fragment_reassembly_tracker #(
  parameter int SLOTS     = 16,
  parameter int MAX_PARTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_conn_id,
  input  logic [15:0] in_msg_id,
  input  logic [15:0] in_frag_index,
  input  logic [15:0] in_frag_count,
  input  logic [63:0] in_now_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_used,
  output logic [15:0] out_done_msg_id,
  output logic [4:0]  out_dropped_now,
  output logic [63:0] out_dropped_total,
  output logic        out_consistent,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int CW   = $clog2(MAX_PARTS + 1);

  typedef struct packed {
    logic [31:0]          key;
    logic [CW-1:0]        total;
    logic [63:0]          start;
    logic [MAX_PARTS-1:0] seen;
    logic [CW-1:0]        have;
  } entry_t;

  entry_t mem [SLOTS];

  frt_pkg::state_t state_r, state_nxt;
  frt_pkg::ctrl_t  ctrl;

  logic [63:0]      budget_r;
  logic [SLOTS-1:0] valid_r;
  logic [63:0]      drop_cnt_r;

  logic [1:0]  act_r;
  logic [31:0] key_r;
  logic [15:0] msg_r, idx_r, cnt_in_r;
  logic [63:0] now_r;
  logic        skip_r;

  logic [CNTW-1:0] cnt_r;
  logic            q_r;
  logic [SW-1:0]   q_addr_r;
  entry_t          rd_data_r;

  logic          hit_r, free_r;
  logic [SW-1:0] hit_slot_r, free_slot_r;
  entry_t        hit_ent_r;
  logic [4:0]    dropped_r;
  logic          cons_r;

  logic [1:0]  status_r;
  logic [3:0]  slot_used_r;
  logic [15:0] done_r;
  logic        out_cons_r;
  logic [4:0]  out_drop_r;

  logic scan_done, q_valid_slot, q_expired, bad_frag;
  logic [63:0] age;

  // finish stage
  entry_t               base, upd;
  logic [MAX_PARTS-1:0] bitm;
  logic                 new_bit, complete;
  logic [SW-1:0]        tgt;

  logic [1:0]  status_nxt;
  logic [3:0]  slot_nxt;
  logic [15:0] done_nxt;
  logic [4:0]  drop_nxt;
  logic        cons_nxt;
  logic        wr_en;
  logic        conflict;

  assign pready = 1'b1;
  assign prdata = (paddr == frt_pkg::ADDR_BUDGET) ? budget_r : 64'd0;

  assign bad_frag = (in_frag_count == 16'd0) || (in_frag_index >= in_frag_count) ||
                    (32'(in_frag_count) > 32'(MAX_PARTS));

  assign scan_done    = (cnt_r == CNTW'(SLOTS)) && !q_r;
  assign q_valid_slot = valid_r[q_addr_r];
  assign age          = now_r - rd_data_r.start;
  assign q_expired    = (now_r >= rd_data_r.start) && (age > budget_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frt_pkg::ST_IDLE:   if (in_valid) state_nxt = frt_pkg::ST_SCAN;
      frt_pkg::ST_SCAN:   if (skip_r || scan_done) state_nxt = frt_pkg::ST_FINISH;
      frt_pkg::ST_FINISH: state_nxt = frt_pkg::ST_OUT;
      frt_pkg::ST_OUT:    if (!out_stall) state_nxt = frt_pkg::ST_IDLE;
      default:            state_nxt = frt_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      frt_pkg::ST_IDLE:   ctrl.in_stall = 1'b0;
      frt_pkg::ST_SCAN: begin
        ctrl.in_stall = 1'b1;
        ctrl.rd_en    = !skip_r && (cnt_r != CNTW'(SLOTS));
      end
      frt_pkg::ST_FINISH: ctrl.in_stall = 1'b1;
      frt_pkg::ST_OUT: begin
        ctrl.in_stall  = 1'b1;
        ctrl.out_valid = 1'b1;
      end
      default:            ctrl.in_stall = 1'b1;
    endcase
  end

  assign in_stall = ctrl.in_stall;
  assign out_valid = ctrl.out_valid;

  // fragment update
  always_comb begin
    base = '0;
    base.key   = key_r;
    base.total = CW'(cnt_in_r);
    base.start = now_r;
    if (hit_r) base = hit_ent_r;
    bitm    = MAX_PARTS'(1) << idx_r;
    new_bit = (base.seen & bitm) == '0;
    upd      = base;
    upd.seen = base.seen | bitm;
    upd.have = base.have + CW'(new_bit);
    complete = (upd.have == upd.total);
    tgt      = hit_r ? hit_slot_r : free_slot_r;
  end

  // result of the finished sweep
  always_comb begin
    conflict   = hit_r && (16'(hit_ent_r.total) != cnt_in_r);
    status_nxt = frt_pkg::STS_REJECTED;
    slot_nxt   = '0;
    done_nxt   = '0;
    drop_nxt   = '0;
    cons_nxt   = 1'b0;
    wr_en      = 1'b0;
    if (!skip_r) begin
      unique case (act_r)
        frt_pkg::ACT_ACCEPT: begin
          if (!conflict) begin
            if (!hit_r && !free_r) begin
              status_nxt = frt_pkg::STS_NO_SLOT;
            end else begin
              wr_en    = 1'b1;
              slot_nxt = 4'(tgt);
              if (complete) begin
                status_nxt = frt_pkg::STS_COMPLETED;
                done_nxt   = msg_r;
              end else begin
                status_nxt = frt_pkg::STS_INCOMPLETE;
              end
            end
          end
        end
        frt_pkg::ACT_PRUNE: drop_nxt = dropped_r;
        frt_pkg::ACT_CHECK: cons_nxt = cons_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) rd_data_r <= mem[cnt_r[SW-1:0]];
    if (state_r == frt_pkg::ST_FINISH && wr_en) begin
      mem[tgt] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= frt_pkg::ST_IDLE;
      budget_r   <= frt_pkg::BUDGET_RESET;
      valid_r    <= '0;
      drop_cnt_r <= '0;
      q_r        <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && paddr == frt_pkg::ADDR_BUDGET) budget_r <= pwdata;

      q_r      <= ctrl.rd_en;
      q_addr_r <= cnt_r[SW-1:0];
      if (ctrl.rd_en) cnt_r <= cnt_r + CNTW'(1);

      if (state_r == frt_pkg::ST_IDLE && in_valid) begin
        act_r    <= in_action;
        key_r    <= {in_conn_id, in_msg_id};
        msg_r    <= in_msg_id;
        idx_r    <= in_frag_index;
        cnt_in_r <= in_frag_count;
        now_r    <= in_now_tick;
        skip_r   <= (in_action == frt_pkg::ACT_ACCEPT) ? bad_frag :
                    !(in_action == frt_pkg::ACT_PRUNE || in_action == frt_pkg::ACT_CHECK);
        cnt_r    <= '0;
        hit_r    <= 1'b0;
        free_r   <= 1'b0;
        dropped_r <= '0;
        cons_r   <= 1'b1;
      end

      // one slot examined per cycle as its entry returns from memory
      if (q_r) begin
        unique case (act_r)
          frt_pkg::ACT_ACCEPT: begin
            if (q_valid_slot && !hit_r && rd_data_r.key == key_r) begin
              hit_r      <= 1'b1;
              hit_slot_r <= q_addr_r;
              hit_ent_r  <= rd_data_r;
            end
            if (!q_valid_slot && !free_r) begin
              free_r      <= 1'b1;
              free_slot_r <= q_addr_r;
            end
          end
          frt_pkg::ACT_PRUNE: begin
            if (q_valid_slot && q_expired) begin
              valid_r[q_addr_r] <= 1'b0;
              if (dropped_r != 5'd31) dropped_r <= dropped_r + 5'd1;
              drop_cnt_r <= drop_cnt_r + 64'd1;
            end
          end
          frt_pkg::ACT_CHECK: begin
            if (q_valid_slot && q_expired) cons_r <= 1'b0;
          end
          default: ;
        endcase
      end

      if (state_r == frt_pkg::ST_FINISH) begin
        status_r    <= status_nxt;
        slot_used_r <= slot_nxt;
        done_r      <= done_nxt;
        out_drop_r  <= drop_nxt;
        out_cons_r  <= cons_nxt;
        if (wr_en) valid_r[tgt] <= !complete;
      end
    end
  end

  assign out_status        = status_r;
  assign out_slot_used     = slot_used_r;
  assign out_done_msg_id   = done_r;
  assign out_dropped_now   = out_drop_r;
  assign out_dropped_total = drop_cnt_r;
  assign out_consistent    = out_cons_r;

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rd_en |-> state_r == frt_pkg::ST_SCAN)
    else $error("memory read outside sweep");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != frt_pkg::ST_IDLE |-> in_stall)
    else $error("input open while busy");

  a_complete_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frt_pkg::ST_OUT && out_status == frt_pkg::STS_COMPLETED)
      |-> !valid_r[out_slot_used[SW-1:0]] || SLOTS > 16)
    else $error("completed slot still valid");

  a_scan_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frt_pkg::ST_FINISH) |-> !q_r)
    else $error("sweep read still pending at finish");

endmodule

// ===== dv/tb.sv =====
// testbench for the fragment reassembly tracker: directed table, then random phases
module tb;

  localparam int NSLOT     = 16;
  localparam int PARTS_MAX = 64;
  localparam int WD_LIMIT  = 3000;
  localparam int SETTLE    = 40;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] conn;
    logic [15:0] msg;
    logic [15:0] idx;
    logic [15:0] cnt;
    logic [63:0] now;
  } frag_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] done;
    logic [4:0]  dnow;
    logic [63:0] dtot;
    logic        cons;
  } verdict_t;

  typedef struct packed {
    frag_t    f;
    logic     typed;
    verdict_t v;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [15:0] in_conn_id;
  logic [15:0] in_msg_id;
  logic [15:0] in_frag_index;
  logic [15:0] in_frag_count;
  logic [63:0] in_now_tick;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_used;
  logic [15:0] out_done_msg_id;
  logic [4:0]  out_dropped_now;
  logic [63:0] out_dropped_total;
  logic        out_consistent;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  fragment_reassembly_tracker i_dut (.*);

  // shadow of the slot table
  logic [63:0] budget;
  logic        sv_valid [NSLOT];
  logic [31:0] sv_key   [NSLOT];
  logic [6:0]  sv_total [NSLOT];
  logic [63:0] sv_start [NSLOT];
  logic [63:0] sv_seen  [NSLOT];
  logic [6:0]  sv_have  [NSLOT];
  logic [63:0] drops;

  verdict_t pending_q [$];
  row_t     rows [$];
  int       errors;
  bit       hold_req;
  bit       no_idle;
  int       wd_cnt = 0;

  // random-part key pool and per-key counts
  logic [15:0] pool_conn [4];
  logic [15:0] pool_msg  [8];
  logic [6:0]  key_cnt   [32];
  logic [63:0] cur_tick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit aged(int s, logic [63:0] now);
    return (now >= sv_start[s]) && ((now - sv_start[s]) > budget);
  endfunction

  task automatic reassemble(input frag_t f, output verdict_t v);
    int hit;
    int free_s;
    logic [31:0] key;
    logic [63:0] bit_m;
    v = '0;
    hit = -1;
    free_s = -1;
    key = {f.conn, f.msg};
    case (f.action)
      frt_pkg::ACT_ACCEPT: begin
        if (f.cnt != 0 && f.idx < f.cnt && f.cnt <= PARTS_MAX) begin
          for (int s = 0; s < NSLOT; s++) begin
            if (sv_valid[s]) begin
              if (hit < 0 && sv_key[s] == key) hit = s;
            end else if (free_s < 0) begin
              free_s = s;
            end
          end
          if (hit >= 0 && sv_total[hit] != f.cnt[6:0]) begin
            v.status = frt_pkg::STS_REJECTED;
          end else if (hit < 0 && free_s < 0) begin
            v.status = frt_pkg::STS_NO_SLOT;
          end else begin
            if (hit < 0) begin
              hit = free_s;
              sv_valid[hit] = 1'b1;
              sv_key[hit]   = key;
              sv_total[hit] = f.cnt[6:0];
              sv_start[hit] = f.now;
              sv_seen[hit]  = '0;
              sv_have[hit]  = '0;
            end
            bit_m = 64'd1 << f.idx[5:0];
            if ((sv_seen[hit] & bit_m) == 0) begin
              sv_seen[hit] |= bit_m;
              sv_have[hit] = sv_have[hit] + 7'd1;
            end
            v.slot = hit[3:0];
            if (sv_have[hit] == sv_total[hit]) begin
              v.status = frt_pkg::STS_COMPLETED;
              v.done = f.msg;
              sv_valid[hit] = 1'b0;
            end else begin
              v.status = frt_pkg::STS_INCOMPLETE;
            end
          end
        end
      end
      frt_pkg::ACT_PRUNE: begin
        for (int s = 0; s < NSLOT; s++) begin
          if (sv_valid[s] && aged(s, f.now)) begin
            sv_valid[s] = 1'b0;
            if (v.dnow < 5'd31) v.dnow = v.dnow + 5'd1;
            drops = drops + 64'd1;
          end
        end
      end
      frt_pkg::ACT_CHECK: begin
        v.cons = 1'b1;
        for (int s = 0; s < NSLOT; s++)
          if (sv_valid[s] && aged(s, f.now)) v.cons = 1'b0;
      end
      default: ;
    endcase
    v.dtot = drops;
  endtask

  function automatic frag_t mk(logic [1:0] a, logic [15:0] c, logic [15:0] m,
                               logic [15:0] i, logic [15:0] n, logic [63:0] t);
    frag_t f;
    f = '{action: a, conn: c, msg: m, idx: i, cnt: n, now: t};
    return f;
  endfunction

  function automatic verdict_t vd(logic [1:0] st, logic [3:0] sl, logic [15:0] dm,
                                  logic [4:0] dn, logic [63:0] dt, logic c);
    verdict_t v;
    v = '{status: st, slot: sl, done: dm, dnow: dn, dtot: dt, cons: c};
    return v;
  endfunction

  task automatic add_row(input frag_t f, input logic typed, input verdict_t v);
    row_t r;
    r.f = f;
    r.typed = typed;
    r.v = v;
    rows.insert(rows.size(), r);
  endtask

  function automatic frag_t gen_frag();
    frag_t f;
    int    r;
    int    k;
    logic [6:0] n;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) cur_tick = {$urandom, $urandom};
    else cur_tick = cur_tick + 64'($urandom_range(0, 40));
    if (r < 70) begin
      k = $urandom_range(0, 31);
      n = key_cnt[k];
      f = mk(frt_pkg::ACT_ACCEPT, pool_conn[k % 4], pool_msg[k / 4],
             16'($urandom_range(0, n - 1)), {9'd0, n}, cur_tick);
      // occasional broken fragment of a live key
      if ($urandom_range(0, 19) == 0) f.cnt = f.cnt + 16'd1;
      if ($urandom_range(0, 29) == 0) f.idx = f.cnt + 16'($urandom_range(0, 3));
    end else if (r < 80) begin
      f = mk(frt_pkg::ACT_PRUNE, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), cur_tick);
    end else if (r < 88) begin
      f = mk(frt_pkg::ACT_CHECK, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), cur_tick);
    end else if (r < 90) begin
      f = mk(frt_pkg::ACT_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), cur_tick);
    end else begin
      f = mk(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), {$urandom, $urandom});
    end
    return f;
  endfunction

  task automatic new_pool();
    pool_conn[0] = 16'h0000;
    pool_conn[1] = 16'hFFFF;
    pool_conn[2] = 16'($urandom);
    pool_conn[3] = 16'($urandom);
    for (int i = 0; i < 8; i++) pool_msg[i] = 16'($urandom);
    pool_msg[0] = 16'hFFFF;
    for (int i = 0; i < 32; i++)
      key_cnt[i] = ($urandom_range(0, 15) == 0) ? 7'd64 : 7'($urandom_range(1, 6));
  endtask

  task automatic send(input frag_t f, input logic typed, input verdict_t v);
    verdict_t pv;
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_action     <= f.action;
    in_conn_id    <= f.conn;
    in_msg_id     <= f.msg;
    in_frag_index <= f.idx;
    in_frag_count <= f.cnt;
    in_now_tick   <= f.now;
    do @(posedge clk); while (in_stall);
    reassemble(f, pv);
    pending_q.insert(pending_q.size(), typed ? v : pv);
  endtask

  task automatic drain();
    // drop valid first so the last beat is not taken twice
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_budget(input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= frt_pkg::ADDR_BUDGET;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    budget = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic chk(input string name, input logic [63:0] exp_v, input logic [63:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
      end else begin
        e = pending_q.pop_front();
        chk("status", 64'(e.status), 64'(out_status));
        chk("slot_used", 64'(e.slot), 64'(out_slot_used));
        chk("done_msg_id", 64'(e.done), 64'(out_done_msg_id));
        chk("dropped_now", 64'(e.dnow), 64'(out_dropped_now));
        chk("dropped_total", e.dtot, out_dropped_total);
        chk("consistent", 64'(e.cons), 64'(out_consistent));
      end
    end
  end

  // result side back-pressure
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        n = 400;
        hold_req = 1'b0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 10);
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      wd_cnt <= 0;
    end else if (wd_cnt >= WD_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      wd_cnt <= wd_cnt + 1;
    end
  end

  initial begin
    logic [63:0] budgets [5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = '0;
    in_conn_id = '0;
    in_msg_id = '0;
    in_frag_index = '0;
    in_frag_count = '0;
    in_now_tick = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    budget = frt_pkg::BUDGET_RESET;
    drops = '0;
    for (int s = 0; s < NSLOT; s++) begin
      sv_valid[s] = 1'b0;
      sv_key[s] = '0;
      sv_total[s] = '0;
      sv_start[s] = '0;
      sv_seen[s] = '0;
      sv_have[s] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    add_row(mk(frt_pkg::ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1), 1'b1,
            vd(frt_pkg::STS_REJECTED, 0, 0, 0, 0, 0));
    add_row(mk(frt_pkg::ACT_ACCEPT, 1, 1, 0, 0, 0), 1'b1,
            vd(frt_pkg::STS_REJECTED, 0, 0, 0, 0, 0));
    add_row(mk(frt_pkg::ACT_ACCEPT, 1, 1, 5, 5, 0), 1'b1,
            vd(frt_pkg::STS_REJECTED, 0, 0, 0, 0, 0));
    add_row(mk(frt_pkg::ACT_ACCEPT, 1, 1, 0, 65, 0), 1'b1,
            vd(frt_pkg::STS_REJECTED, 0, 0, 0, 0, 0));
    add_row(mk(frt_pkg::ACT_ACCEPT, 16'hFFFF, 16'hFFFF, 0, 1, 0), 1'b1,
            vd(frt_pkg::STS_COMPLETED, 0, 16'hFFFF, 0, 0, 0));
    add_row(mk(frt_pkg::ACT_ACCEPT, 1, 2, 63, 64, 0), 1'b1,
            vd(frt_pkg::STS_INCOMPLETE, 0, 0, 0, 0, 0));
    add_row(mk(frt_pkg::ACT_ACCEPT, 1, 2, 63, 64, 5), 1'b0, '0);   // duplicate part
    add_row(mk(frt_pkg::ACT_ACCEPT, 1, 2, 0, 63, 5), 1'b0, '0);    // count conflict
    add_row(mk(frt_pkg::ACT_CHECK, 0, 0, 0, 0, 600), 1'b0, '0);
    add_row(mk(frt_pkg::ACT_CHECK, 0, 0, 0, 0, 601), 1'b1,
            vd(frt_pkg::STS_REJECTED, 0, 0, 0, 0, 1'b0));
    add_row(mk(frt_pkg::ACT_PRUNE, 0, 0, 0, 0, 601), 1'b1,
            vd(frt_pkg::STS_REJECTED, 0, 0, 1, 1, 0));
    for (int i = 0; i < NSLOT; i++)
      add_row(mk(frt_pkg::ACT_ACCEPT, 2, 16'(i), 0, 2, 1000), 1'b0, '0);
    add_row(mk(frt_pkg::ACT_ACCEPT, 3, 0, 0, 1, 1000), 1'b1,
            vd(frt_pkg::STS_NO_SLOT, 0, 0, 0, 1, 0));
    add_row(mk(frt_pkg::ACT_PRUNE, 0, 0, 0, 0, 500), 1'b0, '0);    // start ticks in the future
    add_row(mk(frt_pkg::ACT_PRUNE, 0, 0, 0, 0, '1), 1'b0, '0);
    foreach (rows[i]) send(rows[i].f, rows[i].typed, rows[i].v);
    drain();

    // random phases, one budget each
    budgets[0] = 64'd0;
    budgets[1] = '1;
    budgets[2] = 64'd200;
    budgets[3] = frt_pkg::BUDGET_RESET;
    budgets[4] = {$urandom, $urandom};
    for (int p = 0; p < 5; p++) begin
      set_budget(budgets[p]);
      new_pool();
      cur_tick = (p == 1) ? 64'hFFFF_FFFF_FFFF_F000 : 64'($urandom_range(0, 5000));
      no_idle = (p == 3);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < 215; n++) send(gen_frag(), 1'b0, '0);
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
